@@ rtl/hsl_hsv_to_rgb_convert_core_macros.svh @@
// Assertion macros for the HSL/HSV to RGB converter checker.
// Self-contained; included by the checker file only.
`ifndef HSL_HSV_TO_RGB_CONVERT_CORE_MACROS_SVH
`define HSL_HSV_TO_RGB_CONVERT_CORE_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define HSLC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HSLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hslc_pkg.sv @@
// Shared types, codes and the sector lookup of the HSL/HSV to RGB converter.
// No dependencies; used by the core and its checker.
package hslc_pkg;

   localparam int HUE_W    = 16;
   localparam int NUM_CHAN = 3;
   localparam int NUM_STG  = 8;

   typedef enum logic {
      MODEL_HSL = 1'b0,
      MODEL_HSV = 1'b1
   } model_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_X    = 2'd1,
      SEL_C    = 2'd2
   } comp_sel_type;

   typedef logic [2:0] sector_type;
   typedef logic [1:0] chan_type;

   localparam chan_type CHAN_RED   = 2'd0;
   localparam chan_type CHAN_GREEN = 2'd1;
   localparam chan_type CHAN_BLUE  = 2'd2;

   // Component placed on a channel for a given 60 degree sector.
   function automatic comp_sel_type comp_sel(input sector_type sector, input chan_type ch);
      comp_sel_type sel_r;
      comp_sel_type sel_g;
      comp_sel_type sel_b;
      comp_sel_type res;
      case (sector)
         3'd0: begin
            sel_r = SEL_C;    sel_g = SEL_X;    sel_b = SEL_ZERO;
         end
         3'd1: begin
            sel_r = SEL_X;    sel_g = SEL_C;    sel_b = SEL_ZERO;
         end
         3'd2: begin
            sel_r = SEL_ZERO; sel_g = SEL_C;    sel_b = SEL_X;
         end
         3'd3: begin
            sel_r = SEL_ZERO; sel_g = SEL_X;    sel_b = SEL_C;
         end
         3'd4: begin
            sel_r = SEL_X;    sel_g = SEL_ZERO; sel_b = SEL_C;
         end
         default: begin
            sel_r = SEL_C;    sel_g = SEL_ZERO; sel_b = SEL_X;
         end
      endcase
      case (ch)
         CHAN_RED:   res = sel_r;
         CHAN_GREEN: res = sel_g;
         CHAN_BLUE:  res = sel_b;
         default:    res = SEL_ZERO;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/hsl_hsv_to_rgb_convert_core.sv @@
// Each accepted request reaches its result through eight register stages.
// Throughput: one request per cycle; a stalled output fills empty stages before backpressure.
// The multipliers are the chroma, hue reciprocal, two scaling, X term and per-channel output divide products.
// Reset clears the stage valid bits only; data registers are not reset.
// Top level of the HSL/HSV to RGB converter; depends on hslc_pkg.
module hsl_hsv_to_rgb_convert_core
   import hslc_pkg::*;
#(
   parameter int CHANNEL_FRAC_BITS = 12,
   parameter int HUE_FRAC_BITS     = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic signed [HUE_W-1:0]        req_hue,
   input  logic [CHANNEL_FRAC_BITS:0]     req_saturation,
   input  logic [CHANNEL_FRAC_BITS:0]     req_light_or_value,
   input  logic [CHANNEL_FRAC_BITS:0]     req_alpha_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [CHANNEL_FRAC_BITS:0]     rsp_red,
   output logic [CHANNEL_FRAC_BITS:0]     rsp_green,
   output logic [CHANNEL_FRAC_BITS:0]     rsp_blue,
   output logic [CHANNEL_FRAC_BITS:0]     rsp_alpha_out
);

   localparam int F        = CHANNEL_FRAC_BITS;
   localparam int CW       = F + 1;
   localparam int ONE      = 1 << F;
   localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
   localparam int SECT     = 60 << HUE_FRAC_BITS;
   localparam int HUE_OFS  = ((32768 + HUE_FULL - 1) / HUE_FULL) * HUE_FULL;
   localparam int HUW      = $clog2(HUE_OFS + 32768);
   localparam int HPW      = $clog2(HUE_FULL);
   localparam int HQ_SH    = HUW + HPW;
   localparam int HQ_MW    = HUW + 2;
   localparam int HQ_PW    = HUW + HQ_MW;
   localparam int QW       = HQ_PW - HQ_SH;
   localparam longint HQ_M = ((longint'(1) << HQ_SH) + HUE_FULL - 1) / HUE_FULL;
   localparam int KW       = $clog2(SECT + 1);
   localparam int CAW      = F + 3;
   localparam int CNW      = 2 * F + 4;
   localparam int TW       = 2 * F + 6;
   localparam int VW       = 2 * F + HUE_FRAC_BITS + 13;
   localparam int XPW      = CNW + KW + 2;
   localparam int RSH      = F + 1 + HUE_FRAC_BITS;
   localparam int YFW      = VW - RSH;
   localparam int YLIM     = 60 * (ONE + 1);
   localparam int YW       = $clog2(YLIM);
   localparam int YQ_SH    = YW + 6;
   localparam int YQ_MW    = YW + 2;
   localparam int YPW      = YW + YQ_MW;
   localparam longint YQ_M = ((longint'(1) << YQ_SH) + 59) / 60;
   localparam longint RND  = longint'(SECT) * longint'(ONE);

   localparam logic signed [VW-1:0] SECT_V = VW'(SECT);
   localparam logic signed [VW-1:0] RND_V  = VW'(RND);

   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] stg_en;
   logic [CW-1:0]      alpha_ff [NUM_STG];

   // Stage 1: hue offset, chroma numerator.
   logic [HUW-1:0]           s1_hu_ff, s1_hu_in;
   logic signed [CNW-1:0]    s1_cnum_ff, s1_cnum_in;
   logic [CW-1:0]            s1_lv_ff;
   logic                     s1_hsv_ff, s1_hsv_in;
   logic signed [CAW-1:0]    lv_ext, d2, d_abs, ca;
   // Stage 2: hue turn count, offset term.
   logic [QW-1:0]            s2_q_ff, s2_q_in;
   logic [HUW-1:0]           s2_hu_ff;
   logic signed [TW-1:0]     s2_t_ff, s2_t_in;
   logic signed [CNW-1:0]    s2_cnum_ff;
   logic [HQ_PW-1:0]         hq_prod;
   // Stage 3: wrapped hue, scaled offset and chroma.
   logic [HPW-1:0]           s3_w_ff, s3_w_in;
   logic [HUW-1:0]           w_full;
   logic signed [VW-1:0]     s3_pt_ff, s3_pt_in, s3_cp_ff, s3_cp_in;
   logic signed [CNW-1:0]    s3_cnum_ff;
   // Stage 4: sector and in-sector weight.
   sector_type               s4_sec_ff, s4_sec_in;
   logic [KW-1:0]            s4_k_ff, s4_k_in;
   logic [HPW-1:0]           r_w;
   logic signed [VW-1:0]     s4_pt_ff, s4_cp_ff;
   logic signed [CNW-1:0]    s4_cnum_ff;
   // Stage 5: secondary component.
   sector_type               s5_sec_ff;
   logic signed [XPW-1:0]    s5_xp_ff, s5_xp_in;
   logic signed [VW-1:0]     s5_pt_ff, s5_cp_ff;
   // Stage 6 to 8: per-channel sum, rounding, divide by sixty and saturation.
   logic signed [VW-1:0]     s6_v_ff  [NUM_CHAN];
   logic signed [VW-1:0]     s6_v_in  [NUM_CHAN];
   logic                     s7_neg_ff [NUM_CHAN];
   logic                     s7_big_ff [NUM_CHAN];
   logic [YW-1:0]            s7_y_ff  [NUM_CHAN];
   logic                     s7_big_in [NUM_CHAN];
   logic [YW-1:0]            s7_y_in  [NUM_CHAN];
   logic signed [VW-1:0]     vr       [NUM_CHAN];
   logic [YFW-1:0]           y_full   [NUM_CHAN];
   logic [YPW-1:0]           yq_prod  [NUM_CHAN];
   logic [CW-1:0]            s8_chan_ff [NUM_CHAN];
   logic [CW-1:0]            s8_chan_in [NUM_CHAN];

   always_comb begin
      stg_en[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         stg_en[i] = !vld_ff[i] || stg_en[i+1];
      end
   end

   assign req_ready = stg_en[0];
   assign rsp_valid = vld_ff[NUM_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stg_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STG; i++) begin
            if (stg_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         alpha_ff[0] <= req_alpha_in;
      end
      for (int i = 1; i < NUM_STG; i++) begin
         if (stg_en[i]) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
      end
   end

   // Stage 1
   always_comb begin
      s1_hsv_in  = (req_type == MODEL_HSV);
      s1_hu_in   = HUW'(int'(req_hue) + HUE_OFS);
      lv_ext     = $signed({2'b00, req_light_or_value});
      d2         = (lv_ext <<< 1) - CAW'(ONE);
      d_abs      = d2[CAW-1] ? -d2 : d2;
      ca         = s1_hsv_in ? lv_ext : (CAW'(ONE) - d_abs);
      s1_cnum_in = CNW'(ca) * CNW'($signed({1'b0, req_saturation}));
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         s1_hu_ff   <= s1_hu_in;
         s1_cnum_ff <= s1_cnum_in;
         s1_lv_ff   <= req_light_or_value;
         s1_hsv_ff  <= s1_hsv_in;
      end
   end

   // Stage 2
   always_comb begin
      hq_prod = HQ_PW'(s1_hu_ff) * HQ_PW'(HQ_M);
      s2_q_in = hq_prod[HQ_PW-1:HQ_SH];
      s2_t_in = (TW'($signed({1'b0, s1_lv_ff})) <<< (F + 1))
              - (s1_hsv_ff ? (TW'(s1_cnum_ff) <<< 1) : TW'(s1_cnum_ff));
   end

   always_ff @(posedge clock) begin
      if (stg_en[1]) begin
         s2_q_ff    <= s2_q_in;
         s2_hu_ff   <= s1_hu_ff;
         s2_t_ff    <= s2_t_in;
         s2_cnum_ff <= s1_cnum_ff;
      end
   end

   // Stage 3
   always_comb begin
      w_full   = s2_hu_ff - HUW'(int'(s2_q_ff) * HUE_FULL);
      s3_w_in  = w_full[HPW-1:0];
      s3_pt_in = VW'(s2_t_ff) * SECT_V;
      s3_cp_in = (VW'(s2_cnum_ff) * SECT_V) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) begin
         s3_w_ff    <= s3_w_in;
         s3_pt_ff   <= s3_pt_in;
         s3_cp_ff   <= s3_cp_in;
         s3_cnum_ff <= s2_cnum_ff;
      end
   end

   // Stage 4
   always_comb begin
      s4_sec_in = '0;
      for (int j = 1; j < 6; j++) begin
         if (s3_w_ff >= HPW'(j * SECT)) begin
            s4_sec_in = s4_sec_in + 3'd1;
         end
      end
      r_w     = s3_w_ff - HPW'(int'(s4_sec_in) * SECT);
      s4_k_in = s4_sec_in[0] ? KW'(SECT - int'(r_w)) : KW'(r_w);
   end

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         s4_sec_ff  <= s4_sec_in;
         s4_k_ff    <= s4_k_in;
         s4_pt_ff   <= s3_pt_ff;
         s4_cp_ff   <= s3_cp_ff;
         s4_cnum_ff <= s3_cnum_ff;
      end
   end

   // Stage 5
   assign s5_xp_in = XPW'(s4_cnum_ff) * $signed(XPW'({s4_k_ff, 1'b0}));

   always_ff @(posedge clock) begin
      if (stg_en[4]) begin
         s5_sec_ff <= s4_sec_ff;
         s5_xp_ff  <= s5_xp_in;
         s5_pt_ff  <= s4_pt_ff;
         s5_cp_ff  <= s4_cp_ff;
      end
   end

   // Stage 6
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         case (comp_sel(s5_sec_ff, chan_type'(ch)))
            SEL_C:   s6_v_in[ch] = s5_pt_ff + s5_cp_ff;
            SEL_X:   s6_v_in[ch] = s5_pt_ff + VW'(s5_xp_ff);
            default: s6_v_in[ch] = s5_pt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[5]) begin
         s6_v_ff <= s6_v_in;
      end
   end

   // Stage 7
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         vr[ch]        = s6_v_ff[ch] + RND_V;
         y_full[ch]    = vr[ch][VW-1:RSH];
         s7_big_in[ch] = (y_full[ch] >= YFW'(YLIM));
         s7_y_in[ch]   = y_full[ch][YW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[6]) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            s7_neg_ff[ch] <= s6_v_ff[ch][VW-1];
            s7_big_ff[ch] <= s7_big_in[ch];
            s7_y_ff[ch]   <= s7_y_in[ch];
         end
      end
   end

   // Stage 8
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         yq_prod[ch] = YPW'(s7_y_ff[ch]) * YPW'(YQ_M);
         if (s7_neg_ff[ch]) begin
            s8_chan_in[ch] = '0;
         end else if (s7_big_ff[ch]) begin
            s8_chan_in[ch] = CW'(ONE);
         end else begin
            s8_chan_in[ch] = yq_prod[ch][YQ_SH+CW-1:YQ_SH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[7]) begin
         s8_chan_ff <= s8_chan_in;
      end
   end

   assign rsp_red       = s8_chan_ff[CHAN_RED];
   assign rsp_green     = s8_chan_ff[CHAN_GREEN];
   assign rsp_blue      = s8_chan_ff[CHAN_BLUE];
   assign rsp_alpha_out = alpha_ff[NUM_STG-1];

endmodule

@@ rtl/hslc_checker.sv @@
// Port-level checker for the HSL/HSV to RGB converter, bound to the core.
// Depends on hslc_pkg and hsl_hsv_to_rgb_convert_core_macros.svh.
`include "hsl_hsv_to_rgb_convert_core_macros.svh"

module hslc_checker
   import hslc_pkg::*;
#(
   parameter int CHANNEL_FRAC_BITS = 12
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [CHANNEL_FRAC_BITS:0] rsp_red,
   input logic [CHANNEL_FRAC_BITS:0] rsp_green,
   input logic [CHANNEL_FRAC_BITS:0] rsp_blue,
   input logic [CHANNEL_FRAC_BITS:0] rsp_alpha_out
);

   localparam int CW = CHANNEL_FRAC_BITS + 1;
   localparam logic [CW-1:0] ONE_V = CW'(1 << CHANNEL_FRAC_BITS);

   `HSLC_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "Result valid right after reset.")

   `HSLC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha_out), "Stalled result changed.")

   `HSLC_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_red <= ONE_V && rsp_green <= ONE_V && rsp_blue <= ONE_V, "Color channel above full scale.")

   `HSLC_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "Request refused with an empty output.")

endmodule

bind hsl_hsv_to_rgb_convert_core hslc_checker #(
   .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
) u_hslc_checker (.*);
